FILE: hdl/morse_audio_decoder_defines.svh
// Assertion macros used by the checker file.
`ifndef MORSE_AUDIO_DECODER_DEFINES_SVH
`define MORSE_AUDIO_DECODER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define MAD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define MAD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/mad_pkg.sv
package mad_pkg;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DOT_MAX     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_LETTER_GAP  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_WORD_GAP    = 3'd4;

  localparam logic [11:0] THRESHOLD_RESET  = 12'd2000;
  localparam logic [15:0] WINDOW_RESET     = 16'd1000;
  localparam logic [7:0]  DOT_MAX_RESET    = 8'd10;
  localparam logic [7:0]  LETTER_GAP_RESET = 8'd18;
  localparam logic [7:0]  WORD_GAP_RESET   = 8'd38;

  localparam int unsigned MAX_CODE_LEN  = 7;
  localparam int unsigned TABLE_ENTRIES = 36;
  localparam logic [7:0]  RUN_MAX       = 8'd255;
  localparam logic [2:0]  LEN_MAX       = 3'd7;

  localparam logic [6:0] CHAR_UNKNOWN = 7'h3F;  // '?'
  localparam logic [6:0] CHAR_WORD    = 7'h5F;  // '_'

  // Completed letter handed from the front end to the output side.
  typedef struct packed {
    logic [6:0] code_bits;
    logic [2:0] code_length;
    logic       word_break;
  } event_t;

  typedef struct packed {
    logic [2:0] len;
    logic [4:0] bits;
    logic [6:0] ch;
  } sym_entry_t;

  localparam sym_entry_t SYM_TABLE [TABLE_ENTRIES] = '{
    '{3'd2, 5'd1,  7'h61}, '{3'd4, 5'd8,  7'h62}, '{3'd4, 5'd10, 7'h63},
    '{3'd3, 5'd4,  7'h64}, '{3'd1, 5'd0,  7'h65}, '{3'd4, 5'd2,  7'h66},
    '{3'd3, 5'd6,  7'h67}, '{3'd4, 5'd0,  7'h68}, '{3'd2, 5'd0,  7'h69},
    '{3'd4, 5'd7,  7'h6A}, '{3'd3, 5'd5,  7'h6B}, '{3'd4, 5'd4,  7'h6C},
    '{3'd2, 5'd3,  7'h6D}, '{3'd2, 5'd2,  7'h6E}, '{3'd3, 5'd7,  7'h6F},
    '{3'd4, 5'd6,  7'h70}, '{3'd4, 5'd13, 7'h71}, '{3'd3, 5'd2,  7'h72},
    '{3'd3, 5'd0,  7'h73}, '{3'd1, 5'd1,  7'h74}, '{3'd3, 5'd1,  7'h75},
    '{3'd4, 5'd1,  7'h76}, '{3'd3, 5'd3,  7'h77}, '{3'd4, 5'd9,  7'h78},
    '{3'd4, 5'd11, 7'h79}, '{3'd4, 5'd12, 7'h7A}, '{3'd5, 5'd31, 7'h30},
    '{3'd5, 5'd15, 7'h31}, '{3'd5, 5'd7,  7'h32}, '{3'd5, 5'd3,  7'h33},
    '{3'd5, 5'd1,  7'h34}, '{3'd5, 5'd0,  7'h35}, '{3'd5, 5'd16, 7'h36},
    '{3'd5, 5'd24, 7'h37}, '{3'd5, 5'd28, 7'h38}, '{3'd5, 5'd30, 7'h39}
  };

  // Entries are unique, so the matches are independent compares OR-ed together.
  function automatic logic [6:0] lookup_char(input logic [2:0] len, input logic [6:0] bits);
    logic [6:0] ch;
    ch = CHAR_UNKNOWN;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (SYM_TABLE[i].len == len && {2'b00, SYM_TABLE[i].bits} == bits) begin
        ch = SYM_TABLE[i].ch;
      end
    end
    return ch;
  endfunction

endpackage

FILE: hdl/mad_front.sv
module mad_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [mad_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mad_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                           sample_valid,
  input  logic [11:0]                    sample,
  output logic                           sample_stall,
  input  logic                           queue_full,
  output logic                           push,
  output mad_pkg::event_t                push_event
);

  logic [11:0] threshold;
  logic [15:0] window_samples;
  logic [7:0]  dot_max_windows;
  logic [7:0]  letter_gap_windows;
  logic [7:0]  word_gap_windows;

  logic [15:0] window_count;
  logic [11:0] window_peak;
  logic        tone_on;
  logic [7:0]  run_windows;
  logic        gap_valid;
  logic [6:0]  code_bits;
  logic [2:0]  code_length;

  logic        tone_on_next;
  logic [7:0]  run_windows_next;
  logic        gap_valid_next;
  logic [6:0]  code_bits_next;
  logic [2:0]  code_length_next;

  logic        accept;
  logic [11:0] peak;
  logic [16:0] count_inc;
  logic        window_end;
  logic [7:0]  run_inc;
  logic        emit;
  logic        dash;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold          <= mad_pkg::THRESHOLD_RESET;
      window_samples     <= mad_pkg::WINDOW_RESET;
      dot_max_windows    <= mad_pkg::DOT_MAX_RESET;
      letter_gap_windows <= mad_pkg::LETTER_GAP_RESET;
      word_gap_windows   <= mad_pkg::WORD_GAP_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        mad_pkg::REG_THRESHOLD:  threshold          <= cfg_data[11:0];
        mad_pkg::REG_WINDOW:     window_samples     <= cfg_data;
        mad_pkg::REG_DOT_MAX:    dot_max_windows    <= cfg_data[7:0];
        mad_pkg::REG_LETTER_GAP: letter_gap_windows <= cfg_data[7:0];
        mad_pkg::REG_WORD_GAP:   word_gap_windows   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign sample_stall = queue_full;
  assign accept       = sample_valid && !queue_full;

  assign peak       = (sample > window_peak) ? sample : window_peak;
  assign count_inc  = {1'b0, window_count} + 17'd1;
  // zero in window_samples behaves as one
  assign window_end = count_inc >= {1'b0, window_samples};
  assign run_inc    = ((tone_on || gap_valid) && run_windows != mad_pkg::RUN_MAX) ?
                      run_windows + 8'd1 : run_windows;
  assign dash       = !(run_inc < dot_max_windows);

  always_comb begin
    tone_on_next     = tone_on;
    run_windows_next = run_windows;
    gap_valid_next   = gap_valid;
    code_bits_next   = code_bits;
    code_length_next = code_length;
    emit             = 1'b0;
    if (window_end) begin
      run_windows_next = run_inc;
      if (peak > threshold && !tone_on) begin
        emit = gap_valid && (run_inc > letter_gap_windows);
        if (emit) begin
          code_bits_next   = '0;
          code_length_next = '0;
        end
        gap_valid_next   = 1'b0;
        tone_on_next     = 1'b1;
        run_windows_next = '0;
      end else if (peak < threshold && tone_on) begin
        // symbols past the storage limit are neither stored nor counted; the length holds at its maximum
        if (code_length < 3'(mad_pkg::MAX_CODE_LEN)) begin
          code_bits_next = {code_bits[5:0], dash};
        end
        if (code_length != mad_pkg::LEN_MAX) begin
          code_length_next = code_length + 3'd1;
        end
        tone_on_next     = 1'b0;
        gap_valid_next   = 1'b1;
        run_windows_next = '0;
      end
    end
  end

  assign push                  = accept && emit;
  assign push_event.code_bits   = code_bits;
  assign push_event.code_length = code_length;
  assign push_event.word_break  = run_inc > word_gap_windows;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_count <= '0;
      window_peak  <= '0;
      tone_on      <= 1'b0;
      run_windows  <= '0;
      gap_valid    <= 1'b0;
      code_bits    <= '0;
      code_length  <= '0;
    end else if (accept) begin
      window_count <= window_end ? 16'd0 : count_inc[15:0];
      window_peak  <= window_end ? 12'd0 : peak;
      tone_on      <= tone_on_next;
      run_windows  <= run_windows_next;
      gap_valid    <= gap_valid_next;
      code_bits    <= code_bits_next;
      code_length  <= code_length_next;
    end
  end

endmodule

FILE: hdl/mad_queue.sv
module mad_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  mad_pkg::event_t push_data,
  output logic            full,
  input  logic            pop,
  output mad_pkg::event_t pop_data,
  output logic            not_empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  mad_pkg::event_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = count == CNT_FULL;
  assign not_empty = count != '0;
  assign pop_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

FILE: hdl/mad_back.sv
module mad_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            queue_valid,
  input  mad_pkg::event_t queue_event,
  output logic            pop,
  output logic            char_valid,
  input  logic            char_stall,
  output logic [6:0]      character,
  output logic            last
);

  logic word_pending;
  logic load;

  // output register is free when empty or being transferred this cycle
  assign load = !char_valid || !char_stall;
  assign pop  = load && !word_pending && queue_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      char_valid   <= 1'b0;
      word_pending <= 1'b0;
    end else if (load) begin
      if (word_pending) begin
        char_valid   <= 1'b1;
        word_pending <= 1'b0;
      end else begin
        char_valid   <= queue_valid;
        word_pending <= queue_valid && queue_event.word_break;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (word_pending) begin
        character <= mad_pkg::CHAR_WORD;
        last      <= 1'b1;
      end else begin
        character <= mad_pkg::lookup_char(queue_event.code_length, queue_event.code_bits);
        last      <= !queue_event.word_break;
      end
    end
  end

endmodule

FILE: hdl/morse_audio_decoder.sv
// channel   dir  handshake                  payload
// sample    in   sample_valid/sample_stall  sample[11:0]
// char      out  char_valid/char_stall      character[6:0], last
// cfg       in   cfg_write                  cfg_index[2:0], cfg_data[15:0]
//
// A sample per cycle unless stalled; front end counts windows and tone state in one step.
// A letter gives one character; with a word break a '_' follows it, with last set.
// sample_stall rises only while the letter queue (QUEUE_DEPTH entries) is full.
// Synchronous reset loads register defaults and clears control state; no clearing pass.
module morse_audio_decoder #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [mad_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mad_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            sample_valid,
  output logic                            sample_stall,
  input  logic [11:0]                     sample,
  output logic                            char_valid,
  input  logic                            char_stall,
  output logic [6:0]                      character,
  output logic                            last
);

  logic            push;
  mad_pkg::event_t push_event;
  logic            queue_full;
  logic            pop;
  mad_pkg::event_t pop_event;
  logic            queue_valid;

  mad_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_valid (sample_valid),
    .sample       (sample),
    .sample_stall (sample_stall),
    .queue_full   (queue_full),
    .push         (push),
    .push_event   (push_event)
  );

  mad_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_event),
    .full      (queue_full),
    .pop       (pop),
    .pop_data  (pop_event),
    .not_empty (queue_valid)
  );

  mad_back u_back (
    .clk         (clk),
    .rst         (rst),
    .queue_valid (queue_valid),
    .queue_event (pop_event),
    .pop         (pop),
    .char_valid  (char_valid),
    .char_stall  (char_stall),
    .character   (character),
    .last        (last)
  );

endmodule

FILE: hdl/mad_checker.sv
`include "morse_audio_decoder_defines.svh"

module mad_checker (
  input logic       clk,
  input logic       rst,
  input logic       char_valid,
  input logic       char_stall,
  input logic [6:0] character,
  input logic       last
);

  logic stalled;
  logic xfer;
  logic is_word;
  logic in_set;

  assign stalled = char_valid && char_stall;
  assign xfer    = char_valid && !char_stall;
  assign is_word = char_valid && character == mad_pkg::CHAR_WORD;
  assign in_set  = (character >= 7'h61 && character <= 7'h7A) ||
                   (character >= 7'h30 && character <= 7'h39) ||
                   character == mad_pkg::CHAR_UNKNOWN || character == mad_pkg::CHAR_WORD;

  // a stalled result holds until transferred
  `MAD_ASSERT_NEXT(a_out_hold, stalled, $stable({char_valid, character, last}), "stalled result changed")

  // a word break always closes the group of results
  `MAD_ASSERT_NOW(a_word_last, is_word, last, "word break without last")

  // a letter without last is followed straight away by the word break
  `MAD_ASSERT_NEXT(a_word_follows, xfer && !last, is_word, "word break missing")

  `MAD_ASSERT_NOW(a_char_set, char_valid, in_set, "character outside alphabet")

endmodule

bind morse_audio_decoder mad_checker u_checker (.*);

FILE: dv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 16;

  typedef struct {
    logic [6:0] glyph;
    logic       fin;
  } char_res_t;

  typedef enum int {WIN_HOT, WIN_QUIET, WIN_LEVEL} win_kind_t;
  typedef enum int {PACE_FREE, PACE_SEND_IDLE, PACE_RECV_STALL, PACE_BOTH} pace_t;

  logic                            clk;
  logic                            rst = 1'b1;
  logic                            cfg_write = 1'b0;
  logic [mad_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [mad_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
  logic                            sample_valid = 1'b0;
  logic                            sample_stall;
  logic [11:0]                     sample = '0;
  logic                            char_valid;
  logic                            char_stall = 1'b0;
  logic [6:0]                      character;
  logic                            last;

  morse_audio_decoder dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .sample(sample),
    .char_valid(char_valid),
    .char_stall(char_stall),
    .character(character),
    .last(last)
  );

  // Letter and digit patterns, same order as glyph_char.
  string glyph_pat [mad_pkg::TABLE_ENTRIES] = '{
    ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
    "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
    "..-", "...-", ".--", "-..-", "-.--", "--..", "-----", ".----", "..---",
    "...--", "....-", ".....", "-....", "--...", "---..", "----."
  };
  string glyph_char = "abcdefghijklmnopqrstuvwxyz0123456789";

  // Register copies
  logic [11:0] thr = mad_pkg::THRESHOLD_RESET;
  logic [15:0] win_len = mad_pkg::WINDOW_RESET;
  logic [7:0]  dot_len = mad_pkg::DOT_MAX_RESET;
  logic [7:0]  lgap = mad_pkg::LETTER_GAP_RESET;
  logic [7:0]  wgap = mad_pkg::WORD_GAP_RESET;

  // Decoder state
  logic [15:0] win_cnt = '0;
  logic [11:0] win_peak = '0;
  logic        tone = 1'b0;
  logic        gap_on = 1'b0;
  logic [7:0]  run_len = '0;
  logic [6:0]  code = '0;
  logic [2:0]  code_len = '0;

  logic [11:0] sample_backlog [$];
  char_res_t   due_chars [$];

  int errors = 0;
  int samples_taken = 0;
  int chars_seen = 0;
  int words_seen = 0;
  int unknown_seen = 0;
  int settings_used = 0;
  int cycle_count = 0;
  int send_pct = 0;
  int stall_pct = 0;
  int pace_left = 0;

  logic [11:0] warmup [10] = '{0, 2000, 1500, 7, 1999, 0, 1024, 2000, 512, 33};
  logic [11:0] directed [16] = '{2000, 4095, 2000, 0, 0, 1999, 2001, 4095, 4095, 5,
                                 0, 0, 0, 0, 2500, 100};

  function automatic logic [6:0] letter_of(input logic [6:0] bits, input logic [2:0] len);
    string pat;
    pat = "";
    for (int i = int'(len) - 1; i >= 0; i--) begin
      if (bits[i]) pat = {pat, "-"};
      else pat = {pat, "."};
    end
    for (int i = 0; i < mad_pkg::TABLE_ENTRIES; i++) begin
      if (pat == glyph_pat[i]) return 7'(glyph_char[i]);
    end
    return mad_pkg::CHAR_UNKNOWN;
  endfunction

  task automatic decode_sample(input logic [11:0] s);
    int nxt;
    logic [11:0] pk;
    if (s > win_peak) win_peak = s;
    nxt = int'(win_cnt) + 1;
    if (nxt < int'(win_len)) begin
      win_cnt = 16'(nxt);
      return;
    end
    pk = win_peak;
    win_cnt = '0;
    win_peak = '0;
    if ((tone || gap_on) && run_len != mad_pkg::RUN_MAX) run_len++;
    if (pk > thr && !tone) begin
      if (gap_on && run_len > lgap) begin
        due_chars.push_back('{letter_of(code, code_len), run_len <= wgap});
        if (run_len > wgap) due_chars.push_back('{mad_pkg::CHAR_WORD, 1'b1});
        code = '0;
        code_len = '0;
      end
      gap_on = 1'b0;
      tone = 1'b1;
      run_len = '0;
    end else if (pk < thr && tone) begin
      if (code_len != mad_pkg::LEN_MAX) begin
        code = {code[5:0], run_len >= dot_len};
        code_len++;
      end
      tone = 1'b0;
      gap_on = 1'b1;
      run_len = '0;
    end
  endtask

  task automatic push_window(input win_kind_t kind, input int count);
    int w, hot;
    logic [11:0] v;
    w = (win_len == 0) ? 1 : int'(win_len);
    repeat (count) begin
      hot = $urandom_range(w - 1, 0);
      for (int i = 0; i < w; i++) begin
        case (kind)
          WIN_HOT:   v = (i != hot) ? 12'($urandom) :
                         (thr == 12'hFFF) ? thr : 12'($urandom_range(4095, int'(thr) + 1));
          WIN_QUIET: v = (thr == 0) ? 12'd0 : 12'($urandom_range(int'(thr) - 1, 0));
          default:   v = (i == hot) ? thr : 12'($urandom_range(int'(thr), 0));
        endcase
        sample_backlog.push_back(v);
      end
    end
  endtask

  task automatic queue_noise(input int n);
    repeat (n) sample_backlog.push_back(12'($urandom));
  endtask

  // One letter: real pattern most of the time, else an overlong code.
  task automatic push_letter(input bit word_end);
    string pat;
    int tone_len, gap_len, dmax, lgap_i, wgap_i;
    dmax = (dot_len == 0) ? 1 : int'(dot_len);
    lgap_i = int'(lgap);
    wgap_i = int'(wgap);
    pat = "";
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(9, 6)) begin
        if ($urandom_range(1) == 1) pat = {pat, "-"};
        else pat = {pat, "."};
      end
    end else begin
      pat = glyph_pat[$urandom_range(mad_pkg::TABLE_ENTRIES - 1)];
    end
    for (int i = 0; i < pat.len(); i++) begin
      if (pat[i] == "-" || dmax == 1) tone_len = $urandom_range(dmax + 2, dmax);
      else tone_len = $urandom_range(dmax - 1, 1);
      push_window(WIN_HOT, tone_len);
      if ($urandom_range(9) == 0) push_window(WIN_LEVEL, 1);
      if (i != pat.len() - 1) gap_len = $urandom_range((lgap_i > 3) ? 3 : lgap_i - 1, 0);
      else if (word_end) gap_len = ((wgap_i > lgap_i) ? wgap_i : lgap_i) + $urandom_range(2);
      else gap_len = lgap_i + $urandom_range(2);
      push_window(WIN_QUIET, 1);
      repeat (gap_len) push_window(($urandom_range(9) == 0) ? WIN_LEVEL : WIN_QUIET, 1);
    end
  endtask

  task automatic queue_traffic(input int budget);
    int goal, w, r;
    w = (win_len == 0) ? 1 : int'(win_len);
    // finish the open window so generated windows line up with the block's
    if (int'(win_cnt) >= w) sample_backlog.push_back(12'd0);
    else if (win_cnt != 0) repeat (w - int'(win_cnt)) sample_backlog.push_back(12'd0);
    goal = sample_backlog.size() + budget;
    while (sample_backlog.size() < goal) begin
      r = $urandom_range(99);
      if (r < 80) push_letter($urandom_range(99) < 30);
      else if (r < 90) queue_noise($urandom_range(8, 1));
      else repeat ($urandom_range(6, 1)) push_window(win_kind_t'($urandom_range(2)), 1);
    end
  endtask

  task automatic write_reg(input logic [mad_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [15:0] value);
    logic [15:0] junk;
    junk = 16'($urandom);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    case (idx)
      mad_pkg::REG_THRESHOLD: begin
        cfg_data <= {junk[15:12], value[11:0]};
        thr = value[11:0];
      end
      mad_pkg::REG_WINDOW: begin
        cfg_data <= value;
        win_len = value;
      end
      mad_pkg::REG_DOT_MAX: begin
        cfg_data <= {junk[15:8], value[7:0]};
        dot_len = value[7:0];
      end
      mad_pkg::REG_LETTER_GAP: begin
        cfg_data <= {junk[15:8], value[7:0]};
        lgap = value[7:0];
      end
      mad_pkg::REG_WORD_GAP: begin
        cfg_data <= {junk[15:8], value[7:0]};
        wgap = value[7:0];
      end
      default: cfg_data <= junk;
    endcase
  endtask

  task automatic set_config(input int t, input int w, input int d, input int l, input int g,
                            input bit spare);
    write_reg(mad_pkg::REG_THRESHOLD, 16'(t));
    write_reg(mad_pkg::REG_WINDOW, 16'(w));
    write_reg(mad_pkg::REG_DOT_MAX, 16'(d));
    write_reg(mad_pkg::REG_LETTER_GAP, 16'(l));
    write_reg(mad_pkg::REG_WORD_GAP, 16'(g));
    if (spare) begin
      for (int i = int'(mad_pkg::REG_WORD_GAP) + 1; i < (1 << mad_pkg::CFG_INDEX_W); i++)
        write_reg(mad_pkg::CFG_INDEX_W'(i), 16'($urandom));
    end
    @(posedge clk);
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  // Sender holds off until every queued sample is in and every character is out.
  task automatic settle();
    while (sample_backlog.size() != 0 || sample_valid || due_chars.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d characters outstanding", cycle_count,
               due_chars.size());
      $display("FAIL");
      $finish;
    end
  end

  // Pacing: random stretches of free flow, sender gaps, receiver stalls, or both.
  always @(posedge clk) begin
    if (pace_left == 0) begin
      pace_left <= $urandom_range(300, 40);
      case (pace_t'($urandom_range(3)))
        PACE_FREE:       begin send_pct <= 0;  stall_pct <= 0;  end
        PACE_SEND_IDLE:  begin send_pct <= 68; stall_pct <= 0;  end
        PACE_RECV_STALL: begin send_pct <= 0;  stall_pct <= 68; end
        default:         begin send_pct <= 9;  stall_pct <= 9;  end
      endcase
    end else begin
      pace_left <= pace_left - 1;
    end
    char_stall <= !rst && ($urandom_range(99) < stall_pct);
  end

  // Sample driver: payload holds while stalled.
  always @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (!sample_valid || !sample_stall) begin
      if (sample_backlog.size() != 0 && $urandom_range(99) >= send_pct) begin
        sample_valid <= 1'b1;
        sample <= sample_backlog.pop_front();
      end else begin
        sample_valid <= 1'b0;
      end
    end
  end

  // Monitor: predict on each sample transfer, check each character transfer.
  always @(posedge clk) begin : watch
    char_res_t want;
    if (!rst) begin
      if (sample_valid && !sample_stall) begin
        decode_sample(sample);
        samples_taken++;
      end
      if (char_valid && !char_stall) begin
        chars_seen++;
        if (character == mad_pkg::CHAR_WORD) words_seen++;
        else if (character == mad_pkg::CHAR_UNKNOWN) unknown_seen++;
        if (due_chars.size() == 0) begin
          errors++;
          $display("%0t: unexpected character %h last %b", $time, character, last);
        end else begin
          want = due_chars.pop_front();
          if (character !== want.glyph) begin
            errors++;
            $display("%0t: character expected %h got %h", $time, want.glyph, character);
          end
          if (last !== want.fin) begin
            errors++;
            $display("%0t: last expected %b got %b", $time, want.fin, last);
          end
        end
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: no window completes; the shorter window later ends it at once.
    foreach (warmup[i]) sample_backlog.push_back(warmup[i]);
    settle();

    set_config(2000, 1, 3, 2, 4, 1'b0);
    foreach (directed[i]) sample_backlog.push_back(directed[i]);
    settle();

    set_config(1800, 1, 3, 3, 6, 1'b1);
    queue_traffic(300);
    settle();

    // Top threshold: nothing can start a tone.
    set_config(4095, 2, 255, 255, 255, 1'b0);
    queue_noise(40);
    settle();

    // Zero threshold and zero window length.
    set_config(0, 0, 1, 1, 1, 1'b0);
    queue_noise(40);
    settle();

    set_config(1000, 0, 1, 1, 1, 1'b0);
    queue_traffic(200);
    settle();

    set_config(1500, 65535, 2, 2, 3, 1'b0);
    queue_noise(15);
    settle();

    set_config(1500, 4, 2, 2, 3, 1'b0);
    queue_traffic(300);
    settle();

    // Run counter saturation on both a tone and a gap.
    set_config(2048, 1, 255, 254, 200, 1'b0);
    push_window(WIN_HOT, 1);
    push_window(WIN_QUIET, 1);
    push_window(WIN_HOT, 256);
    push_window(WIN_QUIET, 258);
    push_window(WIN_HOT, 1);
    push_window(WIN_QUIET, 1);
    settle();

    set_config($urandom_range(3500, 500), 1, 4, 4, 8, 1'b0);
    queue_traffic(300);
    settle();

    $display("Covered %0d samples under %0d register settings.", samples_taken, settings_used);
    $display("Checked %0d characters: %0d word breaks, %0d unknown codes.", chars_seen,
             words_seen, unknown_seen);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hdl
hdl/mad_pkg.sv
hdl/mad_front.sv
hdl/mad_queue.sv
hdl/mad_back.sv
hdl/morse_audio_decoder.sv
hdl/mad_checker.sv
dv/tb_top.sv
